// ===== rtl/nlc_pkg.sv =====
// Shared character codes, recognizer phase codes and class codes for the literal classifier.
package nlc_pkg;

	// Character codes
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_EXP   = 8'h65;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;

	// Float recognizer phases
	localparam int FP_W = 3;
	localparam logic [FP_W-1:0] FP_START   = 3'd0;
	localparam logic [FP_W-1:0] FP_SIGN    = 3'd1;
	localparam logic [FP_W-1:0] FP_INT     = 3'd2;
	localparam logic [FP_W-1:0] FP_FRAC    = 3'd3;
	localparam logic [FP_W-1:0] FP_EXP     = 3'd4;
	localparam logic [FP_W-1:0] FP_EXPSIGN = 3'd5;
	localparam logic [FP_W-1:0] FP_EXPDIG  = 3'd6;
	localparam logic [FP_W-1:0] FP_REJECT  = 3'd7;

	// Rational recognizer phases
	localparam int RP_W = 3;
	localparam logic [RP_W-1:0] RP_START  = 3'd0;
	localparam logic [RP_W-1:0] RP_SIGN   = 3'd1;
	localparam logic [RP_W-1:0] RP_NUM    = 3'd2;
	localparam logic [RP_W-1:0] RP_SLASH  = 3'd3;
	localparam logic [RP_W-1:0] RP_DEN    = 3'd4;
	localparam logic [RP_W-1:0] RP_REJECT = 3'd5;

	// Result classes
	typedef logic [1:0] lit_class_t;
	localparam lit_class_t CLASS_NONE     = 2'd0;
	localparam lit_class_t CLASS_FLOAT    = 2'd1;
	localparam lit_class_t CLASS_RATIONAL = 2'd2;
	localparam lit_class_t CLASS_UNUSED   = 2'd3;

	function automatic logic is_digit(input logic [7:0] c);
		return c inside {[CH_ZERO:CH_NINE]};
	endfunction

	function automatic logic is_sign(input logic [7:0] c);
		return c inside {CH_PLUS, CH_MINUS};
	endfunction

endpackage

// ===== rtl/nlc_float.sv =====
// Float literal recognizer: one phase step per character, cleared at end of token.
module nlc_float (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] ch,
	input  logic       end_mark,
	output logic       accept
);
	import nlc_pkg::*;

	logic [FP_W-1:0] phase_q;
	logic [FP_W-1:0] phase_nxt;
	logic            digit_q;
	logic            digit_nxt;

	// Next phase for one character
	always_comb begin
		phase_nxt = FP_REJECT;
		digit_nxt = digit_q;
		case (phase_q)
			FP_START, FP_SIGN, FP_INT: begin
				if (phase_q == FP_START && is_sign(ch)) begin
					phase_nxt = FP_SIGN;
				end else if (is_digit(ch)) begin
					phase_nxt = FP_INT;
					digit_nxt = 1'b1;
				end else if (ch == CH_DOT) begin
					phase_nxt = FP_FRAC;
				end else if (ch == CH_EXP) begin
					phase_nxt = FP_EXP;
				end
			end
			FP_FRAC: begin
				if (is_digit(ch)) begin
					phase_nxt = FP_FRAC;
					digit_nxt = 1'b1;
				end else if (ch == CH_EXP) begin
					phase_nxt = FP_EXP;
				end
			end
			FP_EXP, FP_EXPSIGN, FP_EXPDIG: begin
				if (phase_q == FP_EXP && is_sign(ch)) begin
					phase_nxt = FP_EXPSIGN;
				end else if (is_digit(ch)) begin
					phase_nxt = FP_EXPDIG;
				end
			end
			default: begin
				phase_nxt = FP_REJECT;
			end
		endcase
	end

	// Advance on each word, return to start at end of token
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= FP_START;
			digit_q <= 1'b0;
		end else if (step) begin
			if (end_mark) begin
				phase_q <= FP_START;
				digit_q <= 1'b0;
			end else begin
				phase_q <= phase_nxt;
				digit_q <= digit_nxt;
			end
		end
	end

	assign accept = digit_q && (phase_q == FP_FRAC || phase_q == FP_EXPDIG);

endmodule

// ===== rtl/nlc_ratio.sv =====
// Rational literal recognizer: one phase step per character, cleared at end of token.
module nlc_ratio (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] ch,
	input  logic       end_mark,
	output logic       accept
);
	import nlc_pkg::*;

	logic [RP_W-1:0] phase_q;
	logic [RP_W-1:0] phase_nxt;

	// Next phase for one character
	always_comb begin
		phase_nxt = RP_REJECT;
		case (phase_q)
			RP_START: begin
				if (is_sign(ch)) begin
					phase_nxt = RP_SIGN;
				end else if (is_digit(ch)) begin
					phase_nxt = RP_NUM;
				end else if (ch == CH_SLASH) begin
					phase_nxt = RP_SLASH;
				end
			end
			RP_SIGN: begin
				if (is_digit(ch)) begin
					phase_nxt = RP_NUM;
				end
			end
			RP_NUM: begin
				if (is_digit(ch)) begin
					phase_nxt = RP_NUM;
				end else if (ch == CH_SLASH) begin
					phase_nxt = RP_SLASH;
				end
			end
			RP_SLASH, RP_DEN: begin
				if (is_digit(ch)) begin
					phase_nxt = RP_DEN;
				end
			end
			default: begin
				phase_nxt = RP_REJECT;
			end
		endcase
	end

	// Advance on each word, return to start at end of token
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= RP_START;
		end else if (step) begin
			if (end_mark) begin
				phase_q <= RP_START;
			end else begin
				phase_q <= phase_nxt;
			end
		end
	end

	// Empty token and empty numerator both count as rational
	assign accept = (phase_q == RP_START || phase_q == RP_NUM || phase_q == RP_DEN);

endmodule

// ===== rtl/numeric_literal_classifier.sv =====
// Top level of the numeric literal classifier: input register, recognizers, result register.
//
// Usage: a token arrives on the slave stream one character per word, s_tdata[7:0]
// holding the character. A word with s_tlast high ends the token; it carries no
// character and its s_tdata is ignored. For every such end word the master
// stream returns one word: m_tdata[1:0] is 0 for not a number, 1 for a float
// literal, 2 for a rational literal (float wins when both match).
// Throughput: one word per cycle unless s_tready is low, with no gaps between
// tokens; the two recognizers take one phase step per character in the cycle
// after it is registered.
// Result path: an end word passes the input register, then the result register,
// which raises m_tvalid; while an earlier result is not taken, the end word waits
// in the input register.
// Reset: arst_n clears both recognizers to the start of a token and empties the
// input and result registers.
// Stall: while a result waits on m_tready, character words keep flowing
// through the recognizers; only a following end word waits in the input
// register, and s_tready drops once that register cannot drain.
module numeric_literal_classifier (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] ch
	input  logic       s_tlast,   // end_mark
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata    // [1:0] literal_class, [7:2] zero
);
	import nlc_pkg::*;

	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       end_s1;
	logic       move_s1;
	logic       float_ok;
	logic       ratio_ok;
	logic       out_valid_q;
	lit_class_t class_q;

	// An end word needs a free result register; characters always drain
	assign move_s1  = valid_s1 && (!end_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || move_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ch_s1  <= s_tdata;
			end_s1 <= s_tlast;
		end
	end

	nlc_float u_float (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (move_s1),
		.ch       (ch_s1),
		.end_mark (end_s1),
		.accept   (float_ok)
	);

	nlc_ratio u_ratio (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (move_s1),
		.ch       (ch_s1),
		.end_mark (end_s1),
		.accept   (ratio_ok)
	);

	// Result register: load on end word, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move_s1 && end_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1 && end_s1) begin
			class_q <= float_ok ? CLASS_FLOAT : (ratio_ok ? CLASS_RATIONAL : CLASS_NONE);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, class_q};

	// A delivered class is never the unused code
	a_class_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[1:0] != CLASS_UNUSED))
		else $error("unused literal class on output");

	// An end word leaving the input register always yields a result next cycle
	a_end_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(move_s1 && end_s1) |=> m_tvalid)
		else $error("end word produced no result");

	// A held result is never overwritten by a following end word
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready && valid_s1 && end_s1) |-> !move_s1)
		else $error("pending result overwritten");

endmodule

// ===== tb/numeric_literal_classifier_tb.sv =====
// Self-checking testbench for the numeric literal classifier: directed tokens, then random tokens.
`timescale 1ns / 1ps

module numeric_literal_classifier_tb;
	import nlc_pkg::*;

	// Receiver stall modes
	localparam int RX_FREE = 0;
	localparam int RX_COIN = 1;
	localparam int RX_SLOW = 2;
	localparam int RX_BEAT = 3;

	localparam int DIR_ROWS     = 8;
	localparam int RANDOM_WORDS = 1850;

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;    // [7:0] ch
	logic       s_tlast;    // end_mark
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;    // [1:0] literal_class, [7:2] zero

	// Predictor state
	logic [FP_W-1:0] float_ph;
	logic            mant_seen;
	logic [RP_W-1:0] ratio_ph;

	lit_class_t expected_class_q[$];
	logic [7:0] tok[$];
	int         fail_count;
	int         words_sent;
	int         burst_left;
	int         gap_left;

	// Receiver pattern state
	int         rx_mode;
	int         rx_mode_left;
	logic [7:0] rx_cnt;

	// Directed tokens: an optional zero byte is inserted at nul_at
	typedef struct packed {
		int         nul_at;
		bit         typed;
		lit_class_t cls;
	} dir_row_t;

	string dir_tok[DIR_ROWS] = '{"", "/5", "-7/", "1.e-5", "e5", "1", "\377", ".5"};
	dir_row_t dir_row[DIR_ROWS] = '{
		'{-1, 1'b1, CLASS_RATIONAL},   // empty token
		'{-1, 1'b1, CLASS_RATIONAL},   // slash first
		'{-1, 1'b1, CLASS_NONE},       // slash with no denominator
		'{-1, 1'b1, CLASS_FLOAT},      // signed exponent
		'{-1, 1'b1, CLASS_NONE},       // exponent with no mantissa digit
		'{ 1, 1'b1, CLASS_NONE},       // zero byte after a digit
		'{-1, 1'b1, CLASS_NONE},       // top byte value
		'{-1, 1'b0, CLASS_NONE}        // fraction only, predicted
	};

	numeric_literal_classifier uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Stop a hung run
	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

	// Advance both recognizers by one character
	task automatic advance_recognizers(input logic [7:0] c);
		logic dig;
		logic sgn;
		dig = (c >= CH_ZERO) && (c <= CH_NINE);
		sgn = (c == CH_PLUS) || (c == CH_MINUS);
		case (float_ph)
			FP_START, FP_SIGN, FP_INT: begin
				if (float_ph == FP_START && sgn) float_ph = FP_SIGN;
				else if (dig) begin
					mant_seen = 1'b1;
					float_ph = FP_INT;
				end else if (c == CH_DOT) float_ph = FP_FRAC;
				else if (c == CH_EXP) float_ph = FP_EXP;
				else float_ph = FP_REJECT;
			end
			FP_FRAC: begin
				if (dig) mant_seen = 1'b1;
				else if (c == CH_EXP) float_ph = FP_EXP;
				else float_ph = FP_REJECT;
			end
			FP_EXP, FP_EXPSIGN, FP_EXPDIG: begin
				if (float_ph == FP_EXP && sgn) float_ph = FP_EXPSIGN;
				else float_ph = dig ? FP_EXPDIG : FP_REJECT;
			end
			default: float_ph = FP_REJECT;
		endcase
		case (ratio_ph)
			RP_START: begin
				if (sgn) ratio_ph = RP_SIGN;
				else if (dig) ratio_ph = RP_NUM;
				else ratio_ph = (c == CH_SLASH) ? RP_SLASH : RP_REJECT;
			end
			RP_SIGN: ratio_ph = dig ? RP_NUM : RP_REJECT;
			RP_NUM: begin
				if (!dig) ratio_ph = (c == CH_SLASH) ? RP_SLASH : RP_REJECT;
			end
			RP_SLASH, RP_DEN: ratio_ph = dig ? RP_DEN : RP_REJECT;
			default: ratio_ph = RP_REJECT;
		endcase
	endtask

	// Classify the finished token and return to the start of a token
	task automatic classify_token(output lit_class_t cls);
		logic flt;
		logic rat;
		flt = mant_seen && (float_ph == FP_FRAC || float_ph == FP_EXPDIG);
		rat = ratio_ph == RP_START || ratio_ph == RP_NUM || ratio_ph == RP_DEN;
		cls = flt ? CLASS_FLOAT : (rat ? CLASS_RATIONAL : CLASS_NONE);
		float_ph  = FP_START;
		mant_seen = 1'b0;
		ratio_ph  = RP_START;
	endtask

	// Drive one word at the falling edge and hold it until accepted
	task automatic send_word(input logic [7:0] c, input logic last);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 32);
			if ($urandom_range(0, 15) == 0) gap_left = $urandom_range(20, 40);
			else if ($urandom_range(0, 2) == 0) gap_left = 0;
			else gap_left = $urandom_range(1, 6);
		end
		while (gap_left > 0) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
			gap_left--;
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		burst_left--;
		words_sent++;
	endtask

	// Send the token in tok plus its end word, and queue the expected class
	task automatic send_token(input bit typed, input lit_class_t typed_cls);
		lit_class_t cls;
		foreach (tok[k]) begin
			send_word(tok[k], 1'b0);
			advance_recognizers(tok[k]);
		end
		send_word(8'($urandom_range(0, 255)), 1'b1);
		classify_token(cls);
		expected_class_q.push_back(typed ? typed_cls : cls);
	endtask

	task automatic hold_until_drained();
		s_tvalid <= 1'b0;
		while (expected_class_q.size() != 0) @(negedge clk);
	endtask

	function automatic logic [7:0] pick_char();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0, 1, 2, 3: return CH_ZERO + 8'($urandom_range(0, 9));
			4: return $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
			5: return CH_DOT;
			6: return CH_EXP;
			7: return CH_SLASH;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [7:0] pick_digit();
		return CH_ZERO + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] pick_sign();
		return $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
	endfunction

	// Build a random token: mostly float or rational shapes, some noise
	task automatic make_token();
		int kind;
		int n;
		tok.delete();
		kind = $urandom_range(0, 19);
		if (kind < 8) begin
			if ($urandom_range(0, 2) == 0) tok.push_back(pick_sign());
			n = $urandom_range(0, 3);
			repeat (n) tok.push_back(pick_digit());
			if ($urandom_range(0, 3) != 0) begin
				tok.push_back(CH_DOT);
				n = $urandom_range(0, 3);
				repeat (n) tok.push_back(pick_digit());
			end
			if ($urandom_range(0, 1) != 0) begin
				tok.push_back(CH_EXP);
				if ($urandom_range(0, 2) == 0) tok.push_back(pick_sign());
				n = $urandom_range(0, 2);
				repeat (n) tok.push_back(pick_digit());
			end
		end else if (kind < 15) begin
			if ($urandom_range(0, 2) == 0) tok.push_back(pick_sign());
			n = $urandom_range(0, 4);
			repeat (n) tok.push_back(pick_digit());
			if ($urandom_range(0, 1) != 0) begin
				tok.push_back(CH_SLASH);
				n = $urandom_range(0, 3);
				repeat (n) tok.push_back(pick_digit());
			end
		end else begin
			n = $urandom_range(0, 6);
			repeat (n) tok.push_back(pick_char());
		end
		// break some well-formed tokens
		if (kind < 15 && tok.size() > 0 && $urandom_range(0, 7) == 0)
			tok[$urandom_range(0, tok.size() - 1)] = pick_char();
	endtask

	// Receiver: stall on a pattern that changes mode now and then
	always @(negedge clk) begin
		if (rx_mode_left == 0) begin
			rx_mode      <= $urandom_range(RX_FREE, RX_BEAT);
			rx_mode_left <= $urandom_range(50, 400);
		end else begin
			rx_mode_left <= rx_mode_left - 1;
		end
		rx_cnt <= rx_cnt + 8'd1;
		case (rx_mode)
			RX_FREE: m_tready <= 1'b1;
			RX_COIN: m_tready <= 1'($urandom_range(0, 1));
			RX_SLOW: m_tready <= ($urandom_range(0, 7) == 0);
			default: m_tready <= (rx_cnt[2:0] != 3'd0) && (rx_cnt[2:0] != 3'd3);
		endcase
	end

	// Check each accepted result word against the oldest expectation
	always @(posedge clk) begin
		lit_class_t exp_cls;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_class_q.size() == 0) begin
				$error("literal_class: no result expected, actual %0d", m_tdata[1:0]);
				fail_count++;
			end else begin
				exp_cls = expected_class_q.pop_front();
				if (m_tdata[1:0] !== exp_cls) begin
					$error("literal_class mismatch: expected %0d, actual %0d",
						exp_cls, m_tdata[1:0]);
					fail_count++;
				end
				if (m_tdata[7:2] !== 6'd0) begin
					$error("m_tdata pad mismatch: expected 0, actual %0h", m_tdata[7:2]);
					fail_count++;
				end
			end
		end
	end

	initial begin
		bit drained_mid;
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = 8'h00;
		s_tlast      = 1'b0;
		m_tready     = 1'b0;
		rx_mode      = RX_FREE;
		rx_mode_left = 0;
		rx_cnt       = 8'd0;
		fail_count   = 0;
		words_sent   = 0;
		burst_left   = 0;
		gap_left     = 0;
		drained_mid  = 1'b0;
		float_ph     = FP_START;
		mant_seen    = 1'b0;
		ratio_ph     = RP_START;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed tokens
		for (int i = 0; i < DIR_ROWS; i++) begin
			tok.delete();
			for (int k = 0; k < dir_tok[i].len(); k++) begin
				if (k == dir_row[i].nul_at) tok.push_back(8'h00);
				tok.push_back(dir_tok[i][k]);
			end
			if (dir_row[i].nul_at == dir_tok[i].len()) tok.push_back(8'h00);
			send_token(dir_row[i].typed, dir_row[i].cls);
		end
		hold_until_drained();

		// Random tokens
		while (words_sent < DIR_ROWS * 4 + RANDOM_WORDS) begin
			if (!drained_mid && words_sent >= 1000) begin
				hold_until_drained();
				drained_mid = 1'b1;
			end
			make_token();
			send_token(1'b0, CLASS_NONE);
		end

		hold_until_drained();
		repeat (10) @(negedge clk);
		if (fail_count == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end

endmodule
